[rtl/wrte_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the weighted random tree explorer.
// No dependencies; used by the top level.
package wrte_pkg;

	localparam int NODES_DEF        = 2048;
	localparam int MAX_CHILDREN_DEF = 256;

	localparam int COUNT_W = 9;
	localparam int DRAW_W  = 16;
	localparam int PICK_W  = 9;
	localparam int STAT_W  = 3;

	localparam logic [STAT_W-1:0] ST_CHOSEN   = 3'd0;
	localparam logic [STAT_W-1:0] ST_ENDED    = 3'd1;
	localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_OPEN  = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

endpackage

[rtl/weighted_random_tree_explorer.sv]
`timescale 1ns / 1ps
// Top level of the weighted random tree explorer: node record memory and sequencer.
// Depends on wrte_pkg and wrte_ram.
//
// Usage: each input transfer on s_* carries a choice count and a random draw
// for the current node of the stored tree. The block answers with exactly one
// output transfer on m_* holding the 1-based picked child and a status.
// A count of zero ends the path, closes nodes upward and restarts at the root.
// Only one item is in work at a time; s_tready is high while the sequencer is
// idle, also while a finished result still waits on m_*.
// Each item, from the accepting cycle on, goes through the node record memory,
// which has one write port and one registered read port. An error or a path
// end reads the node, plus one step per ancestor reached while closing; a pick
// sums the child weights, runs the 16 remainder steps and scans the children,
// plus one write per child and one step per ancestor when the node is
// expanded. Worst case: 256 children expanded under a path of about 1800 nodes.
// Reset sets the tree to a lone unexpanded root; memory entries at or above the
// allocation pointer read as empty, so no clearing pass is needed.
// When the receiver stalls, the result holds on m_tdata and the sequencer
// waits at its final step until the output register frees.
module weighted_random_tree_explorer #(
	parameter int NODES        = wrte_pkg::NODES_DEF,
	parameter int MAX_CHILDREN = wrte_pkg::MAX_CHILDREN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [8:0] choice_total, [24:9] random_draw
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [8:0] picked, [11:9] status
);

	localparam int IW  = $clog2(NODES);
	localparam int NFW = IW + 1;
	localparam int LW  = $clog2(NODES + 1);
	localparam int RW  = LW + 1;
	localparam int TW  = $clog2(MAX_CHILDREN + 1);
	localparam int OW  = TW + 1;
	localparam int KW  = wrte_pkg::COUNT_W + 1;
	localparam int CW  = wrte_pkg::COUNT_W;
	localparam int DW  = wrte_pkg::DRAW_W;
	localparam int BW  = $clog2(DW);

	typedef struct packed {
		logic [IW-1:0]        parent;
		logic [IW-1:0]        first;
		logic [LW-1:0]        leaf;
		logic signed [OW-1:0] open;
		logic [TW-1:0]        total;
	} rec_t;

	localparam rec_t REC_RESET = '{parent: '0, first: '0, leaf: '0, open: '1, total: '0};

	typedef enum logic [3:0] {
		S_IDLE, S_NODE, S_KIDS, S_ANC, S_SUM, S_MOD, S_PICK, S_CLOSE, S_DONE
	} state_t;

	state_t                    state_q;
	logic [IW-1:0]             cur_q, node_q, x_q, base_q, nxt_cur_q;
	logic [NFW-1:0]            nf_q;
	logic                      root_wr_q, rd_ok_q;
	logic [CW-1:0]             count_q;
	logic [DW-1:0]             draw_q;
	logic [KW-1:0]             k_q;
	logic [LW-1:0]             sum_q, acc_q;
	logic [RW-1:0]             rem_q;
	logic [BW-1:0]             bit_q;
	logic [wrte_pkg::PICK_W-1:0] res_pick_q;
	logic [wrte_pkg::STAT_W-1:0] res_stat_q;
	logic                      m_tvalid_q;
	logic [15:0]               m_tdata_q;

	logic [$bits(rec_t)-1:0] ram_rd;
	rec_t                    rec, wr_rec;
	logic                    wr_en;
	logic [IW-1:0]           wr_addr, rd_addr;
	logic                    full, k_last, fits;
	logic [LW-1:0]           add_w, sum_new, acc_new;
	logic [RW-1:0]           rem_t;
	logic                    addr_ok;

	assign rec      = rd_ok_q ? rec_t'(ram_rd) : REC_RESET;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign full = (32'(nf_q) > NODES) || (32'(count_q) > (NODES - 32'(nf_q)));
	assign fits = (32'(count_q) <= MAX_CHILDREN);
	assign k_last  = (32'(k_q) == 32'(count_q));
	assign add_w   = ((k_q != '0) && (rec.open != '0)) ? rec.leaf : '0;
	assign sum_new = LW'(32'(sum_q) + 32'(add_w));
	assign acc_new = LW'(32'(acc_q) + 32'(add_w));
	assign rem_t   = {rem_q[RW-2:0], draw_q[bit_q]};
	assign addr_ok = (rd_addr == '0) ? root_wr_q : ({1'b0, rd_addr} < nf_q);

	// Memory port control follows the sequencer state.
	always_comb begin
		rd_addr = cur_q;
		wr_en   = 1'b0;
		wr_addr = node_q;
		wr_rec  = rec;
		case (state_q)
			S_NODE: begin
				rd_addr = rec.parent;
				if (count_q == '0) begin
					if (rec.open != '0) begin
						wr_en       = 1'b1;
						wr_rec.open = '0;
					end
				end else if (rec.open != '0 && fits && rec.total == '0 && !full) begin
					wr_en        = 1'b1;
					wr_rec.first = IW'(nf_q);
					wr_rec.open  = OW'(count_q);
					wr_rec.total = TW'(count_q);
					wr_rec.leaf  = LW'(32'(rec.leaf) + 32'(count_q));
				end
			end
			S_KIDS: begin
				rd_addr = x_q;
				wr_en   = 1'b1;
				wr_addr = IW'(32'(base_q) + 32'(k_q));
				wr_rec  = '{parent: node_q, first: '0, leaf: LW'(1), open: '1, total: '0};
			end
			S_ANC: begin
				rd_addr     = rec.parent;
				wr_en       = 1'b1;
				wr_addr     = x_q;
				wr_rec.leaf = LW'(32'(rec.leaf) + 32'(count_q));
			end
			S_SUM, S_PICK: begin
				rd_addr = IW'(32'(base_q) + 32'(k_q));
			end
			S_CLOSE: begin
				rd_addr = rec.parent;
				if (rec.open > 0) begin
					wr_en       = 1'b1;
					wr_addr     = x_q;
					wr_rec.open = rec.open - OW'(1);
				end
			end
			default: begin
				rd_addr = cur_q;
			end
		endcase
	end

	wrte_ram #(
		.WIDTH($bits(rec_t)),
		.DEPTH(NODES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_rec),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_q      <= '0;
			nf_q       <= NFW'(1);
			root_wr_q  <= 1'b0;
			rd_ok_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_ok_q <= addr_ok;
			if (wr_en && wr_addr == '0) begin
				root_wr_q <= 1'b1;
			end
			// The final step loads the output register itself.
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						count_q <= s_tdata[CW-1:0];
						draw_q  <= s_tdata[CW+DW-1:CW];
						node_q  <= cur_q;
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					res_pick_q <= '0;
					nxt_cur_q  <= (count_q == '0) ? '0 : cur_q;
					x_q        <= rec.parent;
					k_q        <= '0;
					sum_q      <= '0;
					if (count_q == '0) begin
						res_stat_q <= wrte_pkg::ST_ENDED;
						state_q    <= (rec.open != '0 && node_q != '0) ? S_CLOSE : S_DONE;
					end else if (rec.open == '0) begin
						res_stat_q <= wrte_pkg::ST_NO_OPEN;
						state_q    <= S_DONE;
					end else if (!fits) begin
						res_stat_q <= wrte_pkg::ST_MISMATCH;
						state_q    <= S_DONE;
					end else if (rec.total == '0) begin
						if (full) begin
							res_stat_q <= wrte_pkg::ST_FULL;
							state_q    <= S_DONE;
						end else begin
							base_q  <= IW'(nf_q);
							nf_q    <= NFW'(32'(nf_q) + 32'(count_q));
							state_q <= S_KIDS;
						end
					end else if (32'(rec.total) != 32'(count_q)) begin
						res_stat_q <= wrte_pkg::ST_MISMATCH;
						state_q    <= S_DONE;
					end else begin
						base_q  <= rec.first;
						state_q <= S_SUM;
					end
				end
				S_KIDS: begin
					// k_q counts the children written so far.
					if (32'(k_q) + 1 == 32'(count_q)) begin
						k_q     <= '0;
						state_q <= (node_q == '0) ? S_SUM : S_ANC;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_ANC: begin
					if (x_q == '0) begin
						state_q <= S_SUM;
					end else begin
						x_q <= rec.parent;
					end
				end
				S_SUM: begin
					// Read data is registered and lags the issued address.
					if (k_last) begin
						if (sum_new == '0) begin
							res_stat_q <= wrte_pkg::ST_NO_OPEN;
							state_q    <= S_DONE;
						end else begin
							sum_q   <= sum_new;
							rem_q   <= '0;
							bit_q   <= BW'(DW - 1);
							state_q <= S_MOD;
						end
					end else begin
						sum_q <= sum_new;
						k_q   <= k_q + KW'(1);
					end
				end
				S_MOD: begin
					// One restoring remainder step per cycle, draw bits from the top.
					if (rem_t >= RW'(sum_q)) begin
						rem_q <= rem_t - RW'(sum_q);
					end else begin
						rem_q <= rem_t;
					end
					if (bit_q == '0) begin
						k_q     <= '0;
						acc_q   <= '0;
						state_q <= S_PICK;
					end else begin
						bit_q <= bit_q - BW'(1);
					end
				end
				S_PICK: begin
					if ((k_q != '0) && (rec.open != '0) && (RW'(acc_new) > rem_q)) begin
						res_pick_q <= wrte_pkg::PICK_W'(k_q);
						res_stat_q <= wrte_pkg::ST_CHOSEN;
						nxt_cur_q  <= IW'(32'(base_q) + 32'(k_q) - 1);
						state_q    <= S_DONE;
					end else if (k_last) begin
						res_stat_q <= wrte_pkg::ST_NO_OPEN;
						state_q    <= S_DONE;
					end else begin
						acc_q <= acc_new;
						k_q   <= k_q + KW'(1);
					end
				end
				S_CLOSE: begin
					if (rec.open <= 0 || rec.open != OW'(1) || x_q == '0) begin
						state_q <= S_DONE;
					end else begin
						x_q <= rec.parent;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'b0, res_stat_q, res_pick_q};
						cur_q      <= nxt_cur_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/wrte_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module wrte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
